FILE: rtl/core/bfhp_pkg.sv
// Shared types, constants and the magic prefix table for the bit file header parser.
`timescale 1ns / 1ps

package bfhp_pkg;

    localparam int MagicLen = 13;
    localparam int PosW     = 4;
    localparam int SecW     = 3;

    localparam logic [7:0] KeyE = 8'h65;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_TEXT    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_MAGIC = 2'd1;
    localparam logic [1:0] ERR_EKEY  = 2'd2;

    typedef struct packed {
        logic [1:0]      kind;
        logic [SecW-1:0] section;
        logic [7:0]      data_byte;
        logic [1:0]      error_code;
        logic [31:0]     payload_length;
        logic            header_done;
        logic            payload_last;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [PosW-1:0] pos);
        logic [7:0] val;
        unique case (pos)
            4'd0:    val = 8'h00;
            4'd1:    val = 8'h09;
            4'd2:    val = 8'h0f;
            4'd3:    val = 8'hf0;
            4'd4:    val = 8'h0f;
            4'd5:    val = 8'hf0;
            4'd6:    val = 8'h0f;
            4'd7:    val = 8'hf0;
            4'd8:    val = 8'h0f;
            4'd9:    val = 8'hf0;
            4'd10:   val = 8'h00;
            4'd11:   val = 8'h00;
            4'd12:   val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/core/bfhp_parser.sv
// Parser state registers and the per-byte next-state and result logic.
`timescale 1ns / 1ps

module bfhp_parser #(
    parameter int NUM_INFO = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              start_req,
    output bfhp_pkg::result_t result
);
    import bfhp_pkg::*;

    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_IKEY    = 3'd1;
    localparam logic [2:0] PH_ILEN    = 3'd2;
    localparam logic [2:0] PH_ITEXT   = 3'd3;
    localparam logic [2:0] PH_EKEY    = 3'd4;
    localparam logic [2:0] PH_ELEN    = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    localparam logic [SecW:0]   NumInfoW  = (SecW + 1)'(NUM_INFO);
    localparam logic [PosW-1:0] MagicLast = PosW'(MagicLen - 1);

    logic [2:0]      phase_reg, phase_next, ph;
    logic [PosW-1:0] pos_reg, pos_next, pos;
    logic [SecW-1:0] sec_reg, sec_next, sec;
    logic [31:0]     len_reg, len_next, len;
    logic [31:0]     rem_reg, rem_next, rem;
    logic [1:0]      err_reg, err_next, err;

    logic            wrap;
    logic [1:0]      kind;
    logic [SecW-1:0] out_sec;
    logic [7:0]      out_data;
    logic            last;
    logic [15:0]     ilen;
    logic            done;

    always_comb
    begin
        // A start request clears the state before this byte is parsed.
        ph  = start_req ? PH_MAGIC : phase_reg;
        pos = start_req ? '0 : pos_reg;
        sec = start_req ? '0 : sec_reg;
        len = start_req ? '0 : len_reg;
        rem = start_req ? '0 : rem_reg;
        err = start_req ? ERR_NONE : err_reg;

        phase_next = ph;
        pos_next   = pos;
        sec_next   = sec;
        len_next   = len;
        rem_next   = rem;
        err_next   = err;
        kind       = KIND_HEADER;
        out_sec    = '0;
        out_data   = '0;
        last       = 1'b0;
        ilen       = {len[7:0], in_byte};
        wrap       = ({1'b0, sec} + 1'b1) >= NumInfoW;

        if (err == ERR_NONE)
        begin
            unique case (ph)
                PH_MAGIC:
                begin
                    if (pos > MagicLast || in_byte != magic_byte(pos))
                    begin
                        err_next = ERR_MAGIC;
                    end
                    else if (pos == MagicLast)
                    begin
                        pos_next   = '0;
                        phase_next = PH_IKEY;
                    end
                    else
                    begin
                        pos_next = pos + 1'b1;
                    end
                end
                PH_IKEY:
                begin
                    pos_next   = '0;
                    phase_next = PH_ILEN;
                end
                PH_ILEN:
                begin
                    if (pos == '0)
                    begin
                        len_next = {24'd0, in_byte};
                        pos_next = PosW'(1);
                    end
                    else
                    begin
                        len_next = {16'd0, ilen};
                        pos_next = '0;
                        if (ilen != 16'd0)
                        begin
                            phase_next = PH_ITEXT;
                        end
                        else
                        begin
                            sec_next   = wrap ? '0 : sec + 1'b1;
                            phase_next = wrap ? PH_EKEY : PH_IKEY;
                        end
                    end
                end
                PH_ITEXT:
                begin
                    kind     = KIND_TEXT;
                    out_sec  = sec;
                    out_data = in_byte;
                    len_next = len - 1'b1;
                    if (len == 32'd1)
                    begin
                        pos_next   = '0;
                        sec_next   = wrap ? '0 : sec + 1'b1;
                        phase_next = wrap ? PH_EKEY : PH_IKEY;
                    end
                end
                PH_EKEY:
                begin
                    if (in_byte != KeyE)
                    begin
                        err_next = ERR_EKEY;
                    end
                    else
                    begin
                        pos_next   = '0;
                        len_next   = '0;
                        phase_next = PH_ELEN;
                    end
                end
                PH_ELEN:
                begin
                    len_next = {len[23:0], in_byte};
                    if (pos >= PosW'(3))
                    begin
                        pos_next   = '0;
                        rem_next   = {len[23:0], in_byte};
                        phase_next = ({len[23:0], in_byte} == 32'd0) ? PH_DONE : PH_PAYLOAD;
                    end
                    else
                    begin
                        pos_next = pos + 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    kind     = KIND_PAYLOAD;
                    out_data = in_byte;
                    if (rem <= 32'd1)
                    begin
                        last       = 1'b1;
                        rem_next   = '0;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        rem_next = rem - 1'b1;
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        done = (err_next == ERR_NONE) && (phase_next == PH_PAYLOAD || phase_next == PH_DONE);

        if (err_next != ERR_NONE)
        begin
            result.kind         = KIND_ERROR;
            result.section      = '0;
            result.data_byte    = '0;
            result.payload_last = 1'b0;
        end
        else
        begin
            result.kind         = kind;
            result.section      = out_sec;
            result.data_byte    = out_data;
            result.payload_last = last;
        end
        result.error_code     = err_next;
        result.payload_length = done ? len_next : 32'd0;
        result.header_done    = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            pos_reg   <= '0;
            sec_reg   <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            err_reg   <= ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sec_reg   <= sec_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            err_reg   <= err_next;
        end
    end

endmodule

FILE: rtl/core/bfhp_out_reg.sv
// Result register that holds one finished transaction until the sink takes it.
`timescale 1ns / 1ps

module bfhp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bfhp_pkg::result_t load_data,
    output logic              can_load,
    output logic              valid,
    input  logic              take,
    output bfhp_pkg::result_t data
);
    import bfhp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // A new result may enter in the same cycle the held one leaves.
    assign can_load = !valid_reg || take;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

FILE: rtl/core/bit_file_header_parser_top.sv
// Top level of the bit file header parser: input stream, parser and result register.
//
//  Channel  Dir  Handshake         Contents
//  s_*      in   s_tvalid/tready   tdata = in_byte, tuser = start_req
//  m_*      out  m_tvalid/tready   tdata = header fields, tuser = kind, tlast = payload_last
//
// One byte is accepted per cycle while s_tready is high; its result is registered and
// appears in the result register in the following cycle. The parser state updates in the
// accepting cycle, so the sustained rate is one byte per clock when the sink keeps up.
// Reset clears the parser to the magic check and empties the result register.
// s_tready drops only while a held result is not taken by the sink.
`timescale 1ns / 1ps

module bit_file_header_parser_top #(
    parameter int NUM_INFO = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [2:0] section, [10:3] data_byte, [12:11] error_code,
                                   // [44:13] payload_length, [45] header_done, [47:46] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // payload_last
);
    import bfhp_pkg::*;

    logic    accept;
    logic    can_load;
    result_t step_result;
    result_t held;

    assign s_tready = can_load;
    assign accept   = s_tvalid && can_load;

    bfhp_parser #(
        .NUM_INFO (NUM_INFO)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (s_tdata),
        .start_req (s_tuser),
        .result    (step_result)
    );

    bfhp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s_tvalid),
        .load_data (step_result),
        .can_load  (can_load),
        .valid     (m_tvalid),
        .take      (m_tready),
        .data      (held)
    );

    assign m_tdata = {2'b00, held.header_done, held.payload_length, held.error_code,
                      held.data_byte, held.section};
    assign m_tuser = held.kind;
    assign m_tlast = held.payload_last;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the bit file header parser: directed and random byte streams against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import bfhp_pkg::*;

    localparam int NumInfo = 4;
    localparam int RandomBytes = 1600;
    localparam int StallLimit = 1000;
    localparam logic [MagicLen*8-1:0] MAGIC_PREFIX = 104'h00_09_0f_f0_0f_f0_0f_f0_0f_f0_00_00_01;

    typedef enum logic [2:0] {
        ST_MAGIC,
        ST_INFO_KEY,
        ST_INFO_LEN,
        ST_INFO_TEXT,
        ST_LEN_KEY,
        ST_LEN_VALUE,
        ST_PAYLOAD,
        ST_DONE
    } parse_state_e;

    typedef enum int {
        FILE_CLEAN,
        FILE_BAD_MAGIC,
        FILE_BAD_KEY
    } file_defect_e;

    function automatic logic [7:0] prefix_at(int i);
        return MAGIC_PREFIX[(MagicLen - 1 - i) * 8 +: 8];
    endfunction

    class header_scoreboard;
        result_t      parse_results_q[$];
        parse_state_e state;
        int unsigned  pos;
        logic [2:0]   sec_idx;
        logic [31:0]  len_acc;
        logic [31:0]  bytes_left;
        logic [1:0]   err;
        int           mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            state      = ST_MAGIC;
            pos        = 0;
            sec_idx    = '0;
            len_acc    = '0;
            bytes_left = '0;
            err        = ERR_NONE;
        endfunction

        function void next_section();
            if (int'(sec_idx) + 1 >= NumInfo)
            begin
                sec_idx = '0;
                state   = ST_LEN_KEY;
            end
            else
            begin
                sec_idx = sec_idx + 3'd1;
                state   = ST_INFO_KEY;
            end
            pos = 0;
        endfunction

        // Advances the parser by one byte and queues the result it produces.
        function void note_byte(logic [7:0] b, logic start);
            result_t r;
            logic    done;
            r = '0;
            if (start)
                restart();
            if (err == ERR_NONE)
            begin
                case (state)
                    ST_MAGIC:
                    begin
                        if (b != prefix_at(pos))
                            err = ERR_MAGIC;
                        else
                        begin
                            pos++;
                            if (pos == MagicLen)
                            begin
                                pos   = 0;
                                state = ST_INFO_KEY;
                            end
                        end
                    end
                    ST_INFO_KEY:
                    begin
                        pos   = 0;
                        state = ST_INFO_LEN;
                    end
                    ST_INFO_LEN:
                    begin
                        if (pos == 0)
                        begin
                            len_acc = {24'd0, b};
                            pos     = 1;
                        end
                        else
                        begin
                            len_acc = {16'd0, len_acc[7:0], b};
                            pos     = 0;
                            if (len_acc == 0)
                                next_section();
                            else
                                state = ST_INFO_TEXT;
                        end
                    end
                    ST_INFO_TEXT:
                    begin
                        r.kind      = KIND_TEXT;
                        r.section   = sec_idx;
                        r.data_byte = b;
                        len_acc     = len_acc - 1;
                        if (len_acc == 0)
                            next_section();
                    end
                    ST_LEN_KEY:
                    begin
                        if (b != KeyE)
                            err = ERR_EKEY;
                        else
                        begin
                            pos     = 0;
                            len_acc = '0;
                            state   = ST_LEN_VALUE;
                        end
                    end
                    ST_LEN_VALUE:
                    begin
                        len_acc = {len_acc[23:0], b};
                        pos++;
                        if (pos >= 4)
                        begin
                            pos        = 0;
                            bytes_left = len_acc;
                            state      = (bytes_left == 0) ? ST_DONE : ST_PAYLOAD;
                        end
                    end
                    ST_PAYLOAD:
                    begin
                        r.kind      = KIND_PAYLOAD;
                        r.data_byte = b;
                        if (bytes_left <= 1)
                        begin
                            r.payload_last = 1'b1;
                            bytes_left     = '0;
                            state          = ST_DONE;
                        end
                        else
                            bytes_left = bytes_left - 1;
                    end
                    default: ;
                endcase
            end
            done = (err == ERR_NONE) && (state == ST_PAYLOAD || state == ST_DONE);
            if (err != ERR_NONE)
            begin
                r.kind         = KIND_ERROR;
                r.section      = '0;
                r.data_byte    = '0;
                r.payload_last = 1'b0;
            end
            r.error_code     = err;
            r.payload_length = done ? len_acc : 32'd0;
            r.header_done    = done;
            parse_results_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= 30)
                $display("%0t: mismatch on %s: got %0h, expected %0h",
                         $realtime, what, got, want);
        endtask

        task check_result(result_t got);
            result_t want;
            if (parse_results_q.size() == 0)
            begin
                report("result with no byte outstanding", 32'd0, 32'd0);
                return;
            end
            want = parse_results_q.pop_front();
            if (got.kind != want.kind)
                report("kind", got.kind, want.kind);
            if (got.section != want.section)
                report("section", got.section, want.section);
            if (got.data_byte != want.data_byte)
                report("data_byte", got.data_byte, want.data_byte);
            if (got.error_code != want.error_code)
                report("error_code", got.error_code, want.error_code);
            if (got.payload_length != want.payload_length)
                report("payload_length", got.payload_length, want.payload_length);
            if (got.header_done != want.header_done)
                report("header_done", got.header_done, want.header_done);
            if (got.payload_last != want.payload_last)
                report("payload_last", got.payload_last, want.payload_last);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    header_scoreboard sb = new();
    bit          no_idle = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned file_budget;
    bit          file_start;
    int unsigned stall_cycles = 0;

    bit_file_header_parser_top #(
        .NUM_INFO(NumInfo)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 20);
    end

    // Inputs are noted before results so that a byte is always predicted first.
    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
            begin
                got.kind           = m_tuser;
                got.section        = m_tdata[2:0];
                got.data_byte      = m_tdata[10:3];
                got.error_code     = m_tdata[12:11];
                got.payload_length = m_tdata[44:13];
                got.header_done    = m_tdata[45];
                got.payload_last   = m_tlast;
                sb.check_result(got);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= StallLimit)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic start);
        if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    // Bytes past the budget are dropped, which cuts the file short.
    task automatic file_byte(logic [7:0] b);
        if (file_budget > 0)
        begin
            send_byte(b, file_start);
            file_start = 1'b0;
            file_budget--;
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.parse_results_q.size() != 0);
    endtask

    task automatic send_file(int text_max, logic [31:0] plen, int unsigned payload_sent,
                             file_defect_e defect, int bad_pos, int trailing, bit with_start);
        logic [15:0] tlen;
        logic [7:0]  key;
        file_start = with_start;
        for (int i = 0; i < MagicLen; i++)
        begin
            if (defect == FILE_BAD_MAGIC && i == bad_pos)
            begin
                file_byte(prefix_at(i) ^ 8'($urandom_range(1, 255)));
                break;
            end
            file_byte(prefix_at(i));
        end
        if (defect != FILE_BAD_MAGIC)
        begin
            for (int s = 0; s < NumInfo; s++)
            begin
                tlen = 16'($urandom_range(0, text_max));
                file_byte(8'($urandom));
                file_byte(tlen[15:8]);
                file_byte(tlen[7:0]);
                for (int k = 0; k < int'(tlen); k++)
                    file_byte(8'($urandom));
            end
            if (defect == FILE_BAD_KEY)
            begin
                key = 8'($urandom);
                if (key == KeyE)
                    key = key ^ 8'h01;
                file_byte(key);
            end
            else
            begin
                file_byte(KeyE);
                for (int k = 3; k >= 0; k--)
                    file_byte(plen[k*8 +: 8]);
                for (int unsigned k = 0; k < payload_sent && k < plen; k++)
                    file_byte(8'($urandom));
            end
        end
        // After a defect these bytes only repeat the latched error.
        for (int k = 0; k < trailing; k++)
            file_byte(8'($urandom));
    endtask

    initial
    begin
        int unsigned random_base;
        int unsigned pick;
        int unsigned plen;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty texts and a single payload byte right after reset,
        // trailing bytes, an empty payload, magic errors at both ends, a bad
        // length key and a file cut off by a new start.
        file_budget = 32'hffff_ffff;
        send_file(0, 32'd1, 1, FILE_CLEAN, 0, 2, 1'b0);
        send_file(2, 32'd3, 3, FILE_CLEAN, 0, 0, 1'b1);
        send_file(0, 32'd0, 0, FILE_CLEAN, 0, 2, 1'b1);
        send_file(0, 32'd0, 0, FILE_BAD_MAGIC, 0, 2, 1'b1);
        send_file(0, 32'd0, 0, FILE_BAD_MAGIC, MagicLen - 1, 1, 1'b1);
        send_file(1, 32'd0, 0, FILE_BAD_KEY, 0, 2, 1'b1);
        send_file(0, 32'hffff_ffff, 2, FILE_CLEAN, 0, 0, 1'b1);
        send_file(1, 32'd2, 2, FILE_CLEAN, 0, 1, 1'b1);
        wait_results_drained();

        random_base = bytes_sent;
        while (bytes_sent - random_base < RandomBytes)
        begin
            no_idle = (bytes_sent - random_base >= 600) && (bytes_sent - random_base < 900);
            file_budget = 32'hffff_ffff;
            pick = $urandom_range(0, 99);
            plen = $urandom_range(0, 20);
            if (pick < 58)
                send_file(4, plen, plen, FILE_CLEAN, 0, $urandom_range(0, 3),
                          $urandom_range(0, 9) != 0);
            else if (pick < 68)
            begin
                file_budget = $urandom_range(1, 60);
                send_file(4, plen, plen, FILE_CLEAN, 0, 0, 1'b1);
            end
            else if (pick < 76)
                send_file(4, 0, 0, FILE_BAD_MAGIC, $urandom_range(0, MagicLen - 1),
                          $urandom_range(0, 3), 1'b1);
            else if (pick < 84)
                send_file(4, 0, 0, FILE_BAD_KEY, 0, $urandom_range(0, 3), 1'b1);
            else if (pick < 91)
                send_file(4, $urandom, $urandom_range(0, 12), FILE_CLEAN, 0, 0, 1'b1);
            else if (pick < 97)
            begin
                repeat ($urandom_range(1, 5))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            else
                send_file(270, plen, plen, FILE_CLEAN, 0, 1, 1'b1);
            if ($urandom_range(0, 99) < 5)
                wait_results_drained();
        end
        no_idle = 1'b0;

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.parse_results_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bfhp_pkg.sv
rtl/core/bfhp_parser.sv
rtl/core/bfhp_out_reg.sv
rtl/core/bit_file_header_parser_top.sv
verif/tb_top.sv
